>>> design/djs_pkg.sv
// Package for the deadline job scheduler: sizes, mode codes, register codes, state enum.
// No dependencies.
package djs_pkg;
  localparam int MaxTasks = 16;
  localparam int IdxW     = $clog2(MaxTasks);
  localparam int CntW     = $clog2(MaxTasks + 1);
  localparam int TagW     = 8;
  localparam int DurW     = 16;
  localparam int DlW      = 32;
  localparam int StW      = 31;
  localparam int FinW     = 33;
  localparam int CfgW     = 31;

  localparam logic [1:0] ModeEdd   = 2'd0;
  localparam logic [1:0] ModeSpt   = 2'd1;
  localparam logic [1:0] ModeMoore = 2'd2;

  localparam logic RegMode  = 1'b0;
  localparam logic RegStart = 1'b1;

  typedef enum logic [3:0] {
    StIdle,
    StSortRd,
    StSortCmp,
    StWalkRd,
    StWalkChk,
    StScanRd,
    StScanCmp,
    StEvict,
    StRetry,
    StEmitRd,
    StEmit
  } state_e;
endpackage

>>> design/deadline_job_scheduler.sv
// Deadline job scheduler top level: job table memory, sort, Moore walk, emit.
// Depends on djs_pkg.
//
//  channel | ports                                         | handshake
//  cfg     | cfg_we_i cfg_idx_i cfg_data_i                 | write on we
//  job     | start_i job_tag_i duration_i deadline_i       | start & !busy
//          | last_job_i                                    |
//  result  | out_valid_o out_tag_o is_late_o last_result_o | strobe, 1 cycle
//
// Jobs load at one per cycle while idle. After the last job a stable
// insertion sort runs over the job memory (one read per compare), then in
// Moore mode a walk over the jobs (read, check) with a rescan of the
// schedule for its longest job on each miss while the schedule is not
// empty. Each result is read, then emitted. The job memory has one read
// port. Reset clears control only; results cannot be stalled.
module deadline_job_scheduler (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_idx_i,
  input  logic [djs_pkg::CfgW-1:0] cfg_data_i,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic [djs_pkg::TagW-1:0] job_tag_i,
  input  logic [djs_pkg::DurW-1:0] duration_i,
  input  logic [djs_pkg::DlW-1:0]  deadline_i,
  input  logic                     last_job_i,
  output logic                     out_valid_o,
  output logic [djs_pkg::TagW-1:0] out_tag_o,
  output logic                     is_late_o,
  output logic                     last_result_o
);
  localparam int W = djs_pkg::TagW + djs_pkg::DurW + djs_pkg::DlW;
  localparam int IW = djs_pkg::IdxW;
  localparam int CW = djs_pkg::CntW;

  logic [W-1:0] mem_q [djs_pkg::MaxTasks];
  logic [W-1:0] rd_q;
  logic [IW-1:0] ra;
  logic          re;

  // order list, schedule list, late list (index lists, small registers)
  logic [IW-1:0] ord_q [djs_pkg::MaxTasks];
  logic [IW-1:0] ord_d [djs_pkg::MaxTasks];
  logic [IW-1:0] sch_q [djs_pkg::MaxTasks];
  logic [IW-1:0] sch_d [djs_pkg::MaxTasks];
  logic [IW-1:0] lat_q [djs_pkg::MaxTasks];
  logic [IW-1:0] lat_d [djs_pkg::MaxTasks];

  djs_pkg::state_e st_q, st_d;
  logic [1:0] mode_q;
  logic [djs_pkg::StW-1:0] stt_q;
  logic [CW-1:0] cnt_q, cnt_d, i_q, i_d, j_q, j_d, ns_q, ns_d, nl_q, nl_d;
  logic [CW-1:0] k_q, k_d, best_q, best_d;
  logic [djs_pkg::FinW-1:0] fin_q, fin_d;
  logic [djs_pkg::DurW-1:0] cd_q, cd_d, bd_q, bd_d;
  logic [djs_pkg::DlW-1:0] cdl_q, cdl_d;
  logic [IW-1:0] cur_q, cur_d;
  logic [djs_pkg::DlW-1:0] key_c, key_p;
  logic fits;
  logic [CW-1:0] tot;

  wire take = start_i && !busy_o;
  wire [djs_pkg::DurW-1:0] rd_dur = rd_q[djs_pkg::DlW +: djs_pkg::DurW];
  wire [djs_pkg::DlW-1:0]  rd_dl  = rd_q[djs_pkg::DlW-1:0];

  always_ff @(posedge clk_i) begin
    if (take && cnt_q < CW'(djs_pkg::MaxTasks)) begin
      mem_q[cnt_q[IW-1:0]] <= {job_tag_i, duration_i, deadline_i};
    end
    if (re) begin
      rd_q <= mem_q[ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= djs_pkg::ModeEdd;
      stt_q  <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == djs_pkg::RegMode) mode_q <= cfg_data_i[1:0];
      else stt_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= djs_pkg::StIdle;
      cnt_q <= '0; i_q <= '0; j_q <= '0; ns_q <= '0; nl_q <= '0;
      k_q <= '0; best_q <= '0; fin_q <= '0;
    end else begin
      st_q <= st_d;
      cnt_q <= cnt_d; i_q <= i_d; j_q <= j_d; ns_q <= ns_d; nl_q <= nl_d;
      k_q <= k_d; best_q <= best_d; fin_q <= fin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ord_q <= ord_d; sch_q <= sch_d; lat_q <= lat_d;
    cd_q <= cd_d; bd_q <= bd_d; cdl_q <= cdl_d; cur_q <= cur_d;
  end

  assign busy_o = (st_q != djs_pkg::StIdle);
  assign tot = ns_q + nl_q;
  assign fits = (fin_q + djs_pkg::FinW'(cd_q)) <= djs_pkg::FinW'(cdl_q);
  assign key_p = (mode_q == djs_pkg::ModeSpt) ? djs_pkg::DlW'(rd_dur) : rd_dl;
  assign key_c = (mode_q == djs_pkg::ModeSpt) ? djs_pkg::DlW'(cd_q) : cdl_q;

  always_comb begin
    st_d = st_q; cnt_d = cnt_q; i_d = i_q; j_d = j_q; ns_d = ns_q; nl_d = nl_q;
    k_d = k_q; best_d = best_q; fin_d = fin_q;
    ord_d = ord_q; sch_d = sch_q; lat_d = lat_q;
    cd_d = cd_q; bd_d = bd_q; cdl_d = cdl_q; cur_d = cur_q;
    re = 1'b0; ra = '0;
    out_valid_o = 1'b0; out_tag_o = rd_q[W-1 -: djs_pkg::TagW];
    is_late_o = 1'b0; last_result_o = 1'b0;
    case (st_q)
      djs_pkg::StIdle: begin
        if (take) begin
          if (cnt_q < CW'(djs_pkg::MaxTasks)) begin
            ord_d[cnt_q[IW-1:0]] = cnt_q[IW-1:0];
            cnt_d = cnt_q + 1'b1;
            cd_d = duration_i; cdl_d = deadline_i;
          end
          if (last_job_i) begin
            i_d = CW'(1); ns_d = '0; nl_d = '0;
            fin_d = djs_pkg::FinW'(stt_q);
            // first new key must be loaded: reread item i
            st_d = djs_pkg::StSortRd;
          end
        end
      end
      // stable insertion sort: cur = ord[i], compare ord[j-1]
      djs_pkg::StSortRd: begin
        if (i_q >= cnt_q) begin
          i_d = '0;
          st_d = (mode_q == djs_pkg::ModeMoore) ? djs_pkg::StWalkRd
                                               : djs_pkg::StEmitRd;
          if (mode_q != djs_pkg::ModeMoore) ns_d = cnt_q;
          if (mode_q != djs_pkg::ModeMoore) for (int m = 0; m < djs_pkg::MaxTasks; m++)
            sch_d[m] = ord_q[m];
        end else if (j_q == '0) begin
          // load current
          cur_d = ord_q[i_q[IW-1:0]]; j_d = i_q;
          re = 1'b1; ra = ord_q[i_q[IW-1:0]];
          k_d = '0; st_d = djs_pkg::StSortCmp;
        end else begin
          re = 1'b1; ra = ord_q[j_q[IW-1:0] - 1'b1];
          k_d = CW'(1); st_d = djs_pkg::StSortCmp;
        end
      end
      djs_pkg::StSortCmp: begin
        if (k_q == '0) begin
          cd_d = rd_dur; cdl_d = rd_dl;
          re = 1'b1; ra = ord_q[j_q[IW-1:0] - 1'b1];
          k_d = CW'(1);
        end else if (key_p > key_c) begin
          ord_d[j_q[IW-1:0]] = ord_q[j_q[IW-1:0] - 1'b1];
          if (j_q == CW'(1)) begin
            ord_d[0] = cur_q; i_d = i_q + 1'b1; j_d = '0;
          end else j_d = j_q - 1'b1;
          st_d = djs_pkg::StSortRd;
        end else begin
          ord_d[j_q[IW-1:0]] = cur_q; i_d = i_q + 1'b1; j_d = '0;
          st_d = djs_pkg::StSortRd;
        end
      end
      djs_pkg::StWalkRd: begin
        if (i_q >= cnt_q) begin
          i_d = '0; st_d = djs_pkg::StEmitRd;
        end else begin
          re = 1'b1; ra = ord_q[i_q[IW-1:0]]; cur_d = ra;
          st_d = djs_pkg::StWalkChk;
        end
      end
      djs_pkg::StWalkChk: begin
        cd_d = rd_dur; cdl_d = rd_dl;
        if ((fin_q + djs_pkg::FinW'(rd_dur)) <= djs_pkg::FinW'(rd_dl)) begin
          sch_d[ns_q[IW-1:0]] = cur_q; ns_d = ns_q + 1'b1;
          fin_d = fin_q + djs_pkg::FinW'(rd_dur);
          i_d = i_q + 1'b1; st_d = djs_pkg::StWalkRd;
        end else if (ns_q == '0) begin
          lat_d[nl_q[IW-1:0]] = cur_q; nl_d = nl_q + 1'b1;
          i_d = i_q + 1'b1; st_d = djs_pkg::StWalkRd;
        end else begin
          k_d = '0; best_d = '0; bd_d = '0; st_d = djs_pkg::StScanRd;
        end
      end
      djs_pkg::StScanRd: begin
        if (k_q >= ns_q) st_d = djs_pkg::StEvict;
        else begin
          re = 1'b1; ra = sch_q[k_q[IW-1:0]]; st_d = djs_pkg::StScanCmp;
        end
      end
      djs_pkg::StScanCmp: begin
        if (k_q == '0 || rd_dur > bd_q) begin
          bd_d = rd_dur; best_d = k_q;
        end
        k_d = k_q + 1'b1; st_d = djs_pkg::StScanRd;
      end
      djs_pkg::StEvict: begin
        if (bd_q > cd_q) begin
          fin_d = fin_q - djs_pkg::FinW'(bd_q);
          lat_d[nl_q[IW-1:0]] = sch_q[best_q[IW-1:0]]; nl_d = nl_q + 1'b1;
          for (int m = 0; m < djs_pkg::MaxTasks - 1; m++)
            if (CW'(m) >= best_q) sch_d[m] = sch_q[m+1];
          ns_d = ns_q - 1'b1;
          st_d = djs_pkg::StRetry;
        end else begin
          lat_d[nl_q[IW-1:0]] = cur_q; nl_d = nl_q + 1'b1;
          i_d = i_q + 1'b1; st_d = djs_pkg::StWalkRd;
        end
      end
      djs_pkg::StRetry: begin
        if (fits) begin
          sch_d[ns_q[IW-1:0]] = cur_q; ns_d = ns_q + 1'b1;
          fin_d = fin_q + djs_pkg::FinW'(cd_q);
        end else begin
          lat_d[nl_q[IW-1:0]] = cur_q; nl_d = nl_q + 1'b1;
        end
        i_d = i_q + 1'b1; st_d = djs_pkg::StWalkRd;
      end
      djs_pkg::StEmitRd: begin
        if (i_q >= tot) begin
          cnt_d = '0; ns_d = '0; nl_d = '0; fin_d = '0; i_d = '0; j_d = '0;
          st_d = djs_pkg::StIdle;
        end else begin
          re = 1'b1;
          ra = (i_q < ns_q) ? sch_q[i_q[IW-1:0]] : lat_q[IW'(i_q - ns_q)];
          st_d = djs_pkg::StEmit;
        end
      end
      djs_pkg::StEmit: begin
        out_valid_o = 1'b1;
        is_late_o = (i_q >= ns_q);
        last_result_o = (i_q + 1'b1 == tot);
        i_d = i_q + 1'b1; st_d = djs_pkg::StEmitRd;
      end
      default: st_d = djs_pkg::StIdle;
    endcase
  end
endmodule

>>> design/djs_checker.sv
// Port-level checks for the deadline job scheduler, bound to the top level.
// Depends on deadline_job_scheduler ports only.
module djs_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic last_job_i,
  input logic out_valid_o,
  input logic is_late_o,
  input logic last_result_o
);
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_result_o |=> !out_valid_o) else $error("result after last");
  a_busy_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> busy_o) else $error("result while idle");
  a_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && last_job_i |=> busy_o) else $error("no run");
  a_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |=> !out_valid_o) else $error("back to back results");
  a_late: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && $past(out_valid_o, 2) && $past(is_late_o, 2) |-> is_late_o)
    else $error("schedule after late");
endmodule

bind deadline_job_scheduler djs_checker u_djs_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
  .last_job_i(last_job_i), .out_valid_o(out_valid_o), .is_late_o(is_late_o),
  .last_result_o(last_result_o)
);
